[sv/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define FCAR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define FCAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/fcar_pkg.sv]
package fcar_pkg;

   // Sizes
   localparam int ADC_BITS       = 12;
   localparam int FRAME_CAPACITY = 30;
   localparam int COUNT_W        = $clog2(FRAME_CAPACITY + 1);
   localparam int TICK_W         = 16;
   localparam int SAMPLE_CEILING = 9999;
   localparam int VAL_W          = $clog2(SAMPLE_CEILING + 1);
   localparam int DIGITS         = 4;
   localparam int HEAD_LEN       = 5;
   localparam int MAX_MSG        = HEAD_LEN + DIGITS + 3;
   localparam int POS_W          = $clog2(MAX_MSG);
   localparam int STEP_W         = $clog2(DIGITS + 1);
   localparam int CSR_INDEX_W    = 8;

   typedef logic [7:0]             byte_type;
   typedef logic [ADC_BITS-1:0]    sample_type;
   typedef logic [TICK_W-1:0]      tick_type;
   typedef logic [VAL_W-1:0]       value_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [POS_W-1:0]       pos_type;
   typedef logic [STEP_W-1:0]      step_type;
   typedef logic [3:0]             digit_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Request kinds
   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_TICK = 1'b1
   } command_type;

   // Register indexes
   localparam csr_index_type REG_INITIAL_DELAY = csr_index_type'(0);
   localparam csr_index_type REG_RESEND_PERIOD = csr_index_type'(1);

   localparam tick_type INITIAL_DELAY_RESET = tick_type'(5);
   localparam tick_type RESEND_PERIOD_RESET = tick_type'(300);

   // Characters
   localparam byte_type CH_OPEN  = 8'h21;
   localparam byte_type CH_CLOSE = 8'h23;
   localparam byte_type CH_CR    = 8'h0D;
   localparam byte_type CH_LF    = 8'h0A;
   localparam byte_type CH_A     = 8'h41;
   localparam byte_type CH_D     = 8'h44;
   localparam byte_type CH_C     = 8'h43;
   localparam byte_type CH_EQ    = 8'h3D;
   localparam byte_type CH_R     = 8'h52;
   localparam byte_type CH_S     = 8'h53;
   localparam byte_type CH_T     = 8'h54;
   localparam byte_type CH_O     = 8'h4F;
   localparam byte_type CH_K     = 8'h4B;
   localparam logic [3:0] DIGIT_HI = 4'h3;

   // Report start from the control side
   typedef struct packed {
      logic      valid;
      value_type value;
   } load_type;

   // Header text "!ADC="
   function automatic byte_type head_char(input pos_type pos);
      byte_type ch;
      case (pos)
         pos_type'(0): ch = CH_OPEN;
         pos_type'(1): ch = CH_A;
         pos_type'(2): ch = CH_D;
         pos_type'(3): ch = CH_C;
         default:      ch = CH_EQ;
      endcase
      return ch;
   endfunction

   // Decimal weight of each conversion step, most significant first
   function automatic value_type step_weight(input step_type step);
      value_type w;
      case (step)
         step_type'(0): w = value_type'(1000);
         step_type'(1): w = value_type'(100);
         step_type'(2): w = value_type'(10);
         default:       w = value_type'(1);
      endcase
      return w;
   endfunction

endpackage

[sv/fcar_req_if.sv]
interface fcar_req_if;
   logic                 valid;
   logic                 ready;
   logic                 command;
   fcar_pkg::byte_type   rx_byte;
   fcar_pkg::sample_type adc_sample;

   modport source (output valid, output command, output rx_byte, output adc_sample,
                   input ready);
   modport sink   (input valid, input command, input rx_byte, input adc_sample,
                   output ready);
endinterface

[sv/fcar_rsp_if.sv]
interface fcar_rsp_if;
   logic               valid;
   logic               ready;
   fcar_pkg::byte_type tx_byte;
   logic               last_of_message;

   modport source (output valid, output tx_byte, output last_of_message, input ready);
   modport sink   (input valid, input tx_byte, input last_of_message, output ready);
endinterface

[sv/fcar_csr_if.sv]
interface fcar_csr_if;
   logic                    valid;
   logic                    ready;
   fcar_pkg::csr_index_type index;
   fcar_pkg::tick_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/framed_command_adc_reporter.sv]
// A report passes the input register, serializer state and output register to rsp_chan.
// Throughput: one request per cycle; a tick that reports holds the input register until the
// previous message is on its last byte, so messages of 9 to 12 bytes go out back to back at
// one byte per cycle while rsp_chan is ready, set by the single serializer output register.
// Reset (synchronous, active high) clears reporting, the frame parser and both channels.
module framed_command_adc_reporter (
   input logic        clock,
   input logic        reset,
   fcar_req_if.sink   req_chan,
   fcar_rsp_if.source rsp_chan,
   fcar_csr_if.sink   csr_chan
);

   fcar_pkg::load_type load;
   logic               ser_free;

   // Frame parser, timer and config registers
   fcar_control u_control (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .ser_free (ser_free),
      .load     (load)
   );

   // Report text and output register
   fcar_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .ser_free (ser_free),
      .rsp_chan (rsp_chan)
   );

endmodule

[sv/fcar_control.sv]
`include "assert_macros.svh"

module fcar_control (
   input  logic                clock,
   input  logic                reset,
   fcar_req_if.sink            req_chan,
   fcar_csr_if.sink            csr_chan,
   input  logic                ser_free,
   output fcar_pkg::load_type  load
);

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic                 cmd_ff;
   fcar_pkg::byte_type   byte_ff;
   fcar_pkg::sample_type sample_ff;

   // Frame and timer state
   logic                 hunting_ff, hunting_in;
   fcar_pkg::byte_type   chars_ff [3];
   fcar_pkg::count_type  count_ff, count_in;
   logic                 on_ff, on_in;
   fcar_pkg::tick_type   countdown_ff, countdown_in;
   fcar_pkg::tick_type   delay_ff, period_ff;

   logic is_report;
   logic advance;
   logic accept;
   logic store_char;
   logic match_rst;
   logic match_ok;
   logic [15:0] sample_ext;

   // Config writes are always taken
   assign csr_chan.ready = 1'b1;

   // Stage control: a reporting tick waits for the serializer
   assign is_report = in_valid_ff && (cmd_ff == fcar_pkg::CMD_TICK) && on_ff &&
                      (countdown_ff <= fcar_pkg::tick_type'(1));
   assign advance   = in_valid_ff && (!is_report || ser_free);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept    = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Frame matching
   assign match_rst = (count_ff == fcar_pkg::count_type'(3)) &&
                      (chars_ff[0] == fcar_pkg::CH_R) && (chars_ff[1] == fcar_pkg::CH_S) &&
                      (chars_ff[2] == fcar_pkg::CH_T);
   assign match_ok  = (count_ff == fcar_pkg::count_type'(2)) &&
                      (chars_ff[0] == fcar_pkg::CH_O) && (chars_ff[1] == fcar_pkg::CH_K);

   // Next state for one request
   always_comb begin
      hunting_in   = hunting_ff;
      count_in     = count_ff;
      on_in        = on_ff;
      countdown_in = countdown_ff;
      store_char   = 1'b0;
      if (advance) begin
         if (cmd_ff == fcar_pkg::CMD_BYTE) begin
            if (hunting_ff) begin
               if (byte_ff == fcar_pkg::CH_OPEN) begin
                  hunting_in = 1'b0;
                  count_in   = '0;
               end
            end else if (byte_ff == fcar_pkg::CH_OPEN) begin
               count_in = '0;
            end else if (byte_ff == fcar_pkg::CH_CLOSE) begin
               hunting_in = 1'b1;
               count_in   = '0;
               if (match_rst) begin
                  if (!on_ff) begin
                     on_in        = 1'b1;
                     countdown_in = delay_ff;
                  end
               end else if (match_ok) begin
                  on_in        = 1'b0;
                  countdown_in = '0;
               end
            end else begin
               store_char = count_ff < fcar_pkg::count_type'(3);
               if (count_ff < fcar_pkg::count_type'(fcar_pkg::FRAME_CAPACITY)) begin
                  count_in = count_ff + fcar_pkg::count_type'(1);
               end
            end
         end else if (on_ff) begin
            if (is_report) begin
               countdown_in = period_ff;
            end else begin
               countdown_in = countdown_ff - fcar_pkg::tick_type'(1);
            end
         end
      end
   end

   // Report start with the sample clamped to four digits
   assign sample_ext = 16'(sample_ff);
   assign load.valid = advance && is_report;
   assign load.value = (sample_ext > 16'(fcar_pkg::SAMPLE_CEILING)) ?
                       fcar_pkg::value_type'(fcar_pkg::SAMPLE_CEILING) :
                       fcar_pkg::value_type'(sample_ext);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         hunting_ff   <= 1'b0;
         count_ff     <= '0;
         on_ff        <= 1'b0;
         countdown_ff <= '0;
         delay_ff     <= fcar_pkg::INITIAL_DELAY_RESET;
         period_ff    <= fcar_pkg::RESEND_PERIOD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         hunting_ff   <= hunting_in;
         count_ff     <= count_in;
         on_ff        <= on_in;
         countdown_ff <= countdown_in;
         if (csr_chan.valid) begin
            if (csr_chan.index == fcar_pkg::REG_INITIAL_DELAY) begin
               delay_ff <= csr_chan.data;
            end else if (csr_chan.index == fcar_pkg::REG_RESEND_PERIOD) begin
               period_ff <= csr_chan.data;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_chan.command;
         byte_ff   <= req_chan.rx_byte;
         sample_ff <= req_chan.adc_sample;
      end
      if (store_char) begin
         chars_ff[count_ff[1:0]] <= byte_ff;
      end
   end

   `FCAR_ASSERT(a_count_cap, count_ff <= fcar_pkg::count_type'(fcar_pkg::FRAME_CAPACITY), "frame count beyond capacity")
   `FCAR_ASSERT(a_off_clear, !on_ff |-> (countdown_ff == '0), "countdown running while reporting is off")
   `FCAR_ASSERT_NEXT(a_stall_hold, in_valid_ff && !advance, in_valid_ff && $stable(sample_ff) && $stable(cmd_ff), "stalled request lost")

endmodule

[sv/fcar_serializer.sv]
`include "assert_macros.svh"

module fcar_serializer (
   input  logic               clock,
   input  logic               reset,
   input  fcar_pkg::load_type load,
   output logic               ser_free,
   fcar_rsp_if.source         rsp_chan
);

   logic                         active_ff, active_in;
   fcar_pkg::pos_type            pos_ff, pos_in;
   fcar_pkg::step_type           step_ff, step_in;
   fcar_pkg::value_type          rem_ff, rem_in;
   logic [fcar_pkg::DIGITS-1:0][3:0] digits_ff, digits_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   fcar_pkg::byte_type           tx_byte_ff;
   logic                         last_ff;

   logic                emit;
   logic [2:0]          nd;
   fcar_pkg::pos_type   last_pos;
   fcar_pkg::pos_type   k;
   fcar_pkg::pos_type   j;
   logic [1:0]          sel;
   fcar_pkg::byte_type  ch;
   fcar_pkg::value_type weight;
   fcar_pkg::value_type mult [10];
   fcar_pkg::digit_type digit;

   // Significant digit count, at least one
   always_comb begin
      if (digits_ff[3] != 4'd0) begin
         nd = 3'd4;
      end else if (digits_ff[2] != 4'd0) begin
         nd = 3'd3;
      end else if (digits_ff[1] != 4'd0) begin
         nd = 3'd2;
      end else begin
         nd = 3'd1;
      end
   end

   assign last_pos = fcar_pkg::pos_type'(fcar_pkg::HEAD_LEN + 2) + fcar_pkg::pos_type'(nd);
   assign emit     = active_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign ser_free = !active_ff || (emit && (pos_ff == last_pos));

   // Character at the current position
   always_comb begin
      k   = pos_ff - fcar_pkg::pos_type'(fcar_pkg::HEAD_LEN);
      j   = k - fcar_pkg::pos_type'(nd);
      sel = 2'(fcar_pkg::pos_type'(nd) - fcar_pkg::pos_type'(1) - k);
      if (pos_ff < fcar_pkg::pos_type'(fcar_pkg::HEAD_LEN)) begin
         ch = fcar_pkg::head_char(pos_ff);
      end else if (k < fcar_pkg::pos_type'(nd)) begin
         ch = {fcar_pkg::DIGIT_HI, digits_ff[sel]};
      end else begin
         case (j)
            fcar_pkg::pos_type'(0): ch = fcar_pkg::CH_CLOSE;
            fcar_pkg::pos_type'(1): ch = fcar_pkg::CH_CR;
            default:                ch = fcar_pkg::CH_LF;
         endcase
      end
   end

   // One decimal digit per cycle, by comparison against its multiples
   always_comb begin
      weight = fcar_pkg::step_weight(step_ff);
      for (int d = 0; d < 10; d++) begin
         mult[d] = fcar_pkg::value_type'(d) * weight;
      end
      digit = '0;
      for (int d = 1; d < 10; d++) begin
         if (rem_ff >= mult[d]) begin
            digit = fcar_pkg::digit_type'(d);
         end
      end
   end

   // Sequencing
   always_comb begin
      active_in    = active_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      digits_in    = digits_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load.valid) begin
         active_in = 1'b1;
         pos_in    = '0;
         step_in   = '0;
         rem_in    = load.value;
      end else begin
         if (emit) begin
            if (pos_ff == last_pos) begin
               active_in = 1'b0;
            end else begin
               pos_in = pos_ff + fcar_pkg::pos_type'(1);
            end
         end
         if (step_ff < fcar_pkg::step_type'(fcar_pkg::DIGITS)) begin
            rem_in    = rem_ff - mult[digit];
            digits_in = {digits_ff[fcar_pkg::DIGITS-2:0], digit};
            step_in   = step_ff + fcar_pkg::step_type'(1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= fcar_pkg::step_type'(fcar_pkg::DIGITS);
         pos_ff       <= '0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         pos_ff       <= pos_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      digits_ff <= digits_in;
      if (emit) begin
         tx_byte_ff <= ch;
         last_ff    <= (pos_ff == last_pos);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.tx_byte         = tx_byte_ff;
   assign rsp_chan.last_of_message = last_ff;

   `FCAR_ASSERT(a_pos_bound, active_ff |-> (pos_ff <= last_pos), "position past message end")
   `FCAR_ASSERT(a_digits_ready, (active_ff && (pos_ff >= fcar_pkg::pos_type'(fcar_pkg::HEAD_LEN))) |-> (step_ff == fcar_pkg::step_type'(fcar_pkg::DIGITS)), "digits used before conversion finished")
   `FCAR_ASSERT_NEXT(a_last_ends, emit && (pos_ff == last_pos) && !load.valid, !active_ff && rsp_chan.last_of_message, "message did not end on its last byte")

endmodule
